@@ rtl/core/a64la_pkg.sv @@
// ============================================================================
// a64la_pkg: shared constants for the A64 subset line assembler
// Parser step codes, character codes, instruction words and field widths.
// ============================================================================
package a64la_pkg;

  localparam int unsigned SRC_W   = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OFS_W   = 10;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned NUM_W   = 16;
  localparam int unsigned REG_W   = 5;

  // Parser steps. The mov form walks 1..8, the svc form 9..13 then its
  // newline step, the ret form 14..15 then its newline step.
  localparam logic [STEP_W-1:0] STEP_START    = 5'd0;
  localparam logic [STEP_W-1:0] STEP_MOV_O    = 5'd1;
  localparam logic [STEP_W-1:0] STEP_MOV_V    = 5'd2;
  localparam logic [STEP_W-1:0] STEP_MOV_SP   = 5'd3;
  localparam logic [STEP_W-1:0] STEP_MOV_X    = 5'd4;
  localparam logic [STEP_W-1:0] STEP_REG      = 5'd5;
  localparam logic [STEP_W-1:0] STEP_COMMA    = 5'd6;
  localparam logic [STEP_W-1:0] STEP_HASH     = 5'd7;
  localparam logic [STEP_W-1:0] STEP_IMM      = 5'd8;
  localparam logic [STEP_W-1:0] STEP_SVC_V    = 5'd9;
  localparam logic [STEP_W-1:0] STEP_SVC_C    = 5'd10;
  localparam logic [STEP_W-1:0] STEP_SVC_SP   = 5'd11;
  localparam logic [STEP_W-1:0] STEP_SVC_HASH = 5'd12;
  localparam logic [STEP_W-1:0] STEP_SVC_ZERO = 5'd13;
  localparam logic [STEP_W-1:0] STEP_RET_E    = 5'd14;
  localparam logic [STEP_W-1:0] STEP_RET_T    = 5'd15;
  localparam logic [STEP_W-1:0] STEP_SVC_NL   = 5'd16;
  localparam logic [STEP_W-1:0] STEP_RET_NL   = 5'd17;

  localparam logic [SRC_W-1:0] CH_M     = 8'h6d;
  localparam logic [SRC_W-1:0] CH_O     = 8'h6f;
  localparam logic [SRC_W-1:0] CH_V     = 8'h76;
  localparam logic [SRC_W-1:0] CH_X     = 8'h78;
  localparam logic [SRC_W-1:0] CH_S     = 8'h73;
  localparam logic [SRC_W-1:0] CH_C     = 8'h63;
  localparam logic [SRC_W-1:0] CH_R     = 8'h72;
  localparam logic [SRC_W-1:0] CH_E     = 8'h65;
  localparam logic [SRC_W-1:0] CH_T     = 8'h74;
  localparam logic [SRC_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SRC_W-1:0] CH_HASH  = 8'h23;
  localparam logic [SRC_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [SRC_W-1:0] CH_NL    = 8'h0a;
  localparam logic [SRC_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SRC_W-1:0] CH_NINE  = 8'h39;

  localparam logic [WORD_W-1:0] WORD_MOVZ = 32'hd280_0000;
  localparam logic [WORD_W-1:0] WORD_SVC  = 32'hd400_0001;
  localparam logic [WORD_W-1:0] WORD_RET  = 32'hd65f_03c0;

  localparam logic [NUM_W-1:0] REG_LIMIT = 16'd30;
  localparam logic [CNT_W-1:0] CAP_LIMIT = 11'd1024;
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd64;

  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

endpackage

@@ rtl/core/a64la_in_if.sv @@
// ============================================================================
// a64la_in_if: source byte channel
// Valid/ready channel that carries one source character or the end mark.
// ============================================================================
interface a64la_in_if import a64la_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SRC_W-1:0] src_byte;
  logic             end_mark;

  modport source (output valid, output src_byte, output end_mark, input ready);
  modport sink (input valid, input src_byte, input end_mark, output ready);
endinterface

@@ rtl/core/a64la_out_if.sv @@
// ============================================================================
// a64la_out_if: result channel
// Valid/ready channel that carries an instruction word or the final report.
// ============================================================================
interface a64la_out_if import a64la_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              out_kind;
  logic [WORD_W-1:0] instr_word;
  logic [OFS_W-1:0]  byte_offset;
  logic [CNT_W-1:0]  total_bytes;
  logic              failed;

  modport source (output valid, output out_kind, output instr_word,
                  output byte_offset, output total_bytes, output failed,
                  input ready);
  modport sink (input valid, input out_kind, input instr_word,
                input byte_offset, input total_bytes, input failed,
                output ready);
endinterface

@@ rtl/core/a64la_subset_line_assembler_unit.sv @@
// ============================================================================
// a64_subset_line_assembler_unit: streaming line assembler for an A64 subset
// Parses "mov x<reg>, #<imm>", "svc #0" and "ret" lines one byte at a time,
// emits a 32-bit word per completed line that fits, then a final run report.
// ============================================================================
//
// Channel   Dir  Handshake        Payload
// in_if     in   valid/ready      src_byte[7:0], end_mark
// out_if    out  valid/ready      out_kind, instr_word[31:0], byte_offset[9:0],
//                                 total_bytes[10:0], failed
// cfg_*     in   write enable     cfg_wdata[10:0] = code_capacity
//
// One byte is taken per cycle while the parser is not stalled. A transaction
// lands in the input register; when it is processed, the parser step, the
// number accumulator (one multiply by ten and add) and the capacity check
// update together while any result is loaded into the output register. Only a
// full output register that is not being drained stalls the parser, and then
// the input register holds.
// Reset (synchronous, rst_n low) clears both valid flags and the run state,
// and sets the capacity to 64 bytes.
//
module a64_subset_line_assembler_unit
  import a64la_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  a64la_in_if.sink         in_if,
  a64la_out_if.source      out_if,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  // Input register stage.
  logic             in_valid_r;
  logic [SRC_W-1:0] in_byte_r;
  logic             in_end_r;

  // Run state of the parser.
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;
  logic [REG_W-1:0]  reg_r, reg_nxt;
  logic              digit_seen_r, digit_seen_nxt;
  logic [CNT_W-1:0]  bytes_r, bytes_nxt;
  logic              err_r, err_nxt;
  logic [CNT_W-1:0]  cap_r;

  // Output register stage.
  logic              out_valid_r, res_valid;
  logic              kind_r, kind_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [OFS_W-1:0]  ofs_r, ofs_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              failed_r, failed_nxt;

  logic out_free;
  logic process;

  // The processing stage fires whenever a byte is held and the output slot is
  // free, whether or not the byte produces a result.
  assign out_free = !out_valid_r || out_if.ready;
  assign process  = in_valid_r && out_free;
  assign in_if.ready = !in_valid_r || out_free;

  // Digit handling: the accumulator is widened so that an overflow past
  // 65535 is visible before it is stored.
  logic              is_digit;
  logic [3:0]        digit_val;
  logic [NUM_W+3:0]  acc_x10;
  logic              num_over;

  assign is_digit  = (in_byte_r >= CH_ZERO) && (in_byte_r <= CH_NINE);
  assign digit_val = in_byte_r[3:0];
  assign acc_x10   = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                     + {{NUM_W{1'b0}}, digit_val};
  assign num_over  = |acc_x10[NUM_W+3:NUM_W];

  // Capacity check for a line that completes in this cycle.
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W:0]   bytes_plus4;
  logic             cap_over;

  assign cap_eff     = (cap_r > CAP_LIMIT) ? CAP_LIMIT : cap_r;
  assign bytes_plus4 = {1'b0, bytes_r} + (CNT_W+1)'(4);
  assign cap_over    = bytes_plus4 > {1'b0, cap_eff};

  // Expected character and successor for the fixed-text steps.
  logic [SRC_W-1:0]  exp_char;
  logic [STEP_W-1:0] step_succ;

  always_comb begin
    exp_char  = CH_SPACE;
    step_succ = step_r + STEP_W'(1);
    case (step_r)
      STEP_MOV_O:    exp_char = CH_O;
      STEP_MOV_V:    exp_char = CH_V;
      STEP_MOV_SP:   exp_char = CH_SPACE;
      STEP_MOV_X:    exp_char = CH_X;
      STEP_SVC_V:    exp_char = CH_V;
      STEP_SVC_C:    exp_char = CH_C;
      STEP_SVC_SP:   exp_char = CH_SPACE;
      STEP_SVC_HASH: exp_char = CH_HASH;
      STEP_SVC_ZERO: begin
        exp_char  = CH_ZERO;
        step_succ = STEP_SVC_NL;
      end
      STEP_RET_E:    exp_char = CH_E;
      STEP_RET_T: begin
        exp_char  = CH_T;
        step_succ = STEP_RET_NL;
      end
      default: begin
        exp_char  = CH_SPACE;
        step_succ = step_r + STEP_W'(1);
      end
    endcase
  end

  // Main parser: next run state and the result that this byte causes.
  logic              line_done;
  logic [WORD_W-1:0] line_word;

  always_comb begin
    step_nxt       = step_r;
    acc_nxt        = acc_r;
    reg_nxt        = reg_r;
    digit_seen_nxt = digit_seen_r;
    bytes_nxt      = bytes_r;
    err_nxt        = err_r;
    res_valid      = 1'b0;
    kind_nxt       = KIND_WORD;
    word_nxt       = '0;
    ofs_nxt        = '0;
    total_nxt      = '0;
    failed_nxt     = 1'b0;
    line_done      = 1'b0;
    line_word      = WORD_RET;

    if (process) begin
      if (in_end_r) begin
        // Final report, then a fresh run.
        res_valid      = 1'b1;
        kind_nxt       = KIND_REPORT;
        failed_nxt     = err_r || (step_r != STEP_START);
        total_nxt      = failed_nxt ? '0 : bytes_r;
        step_nxt       = STEP_START;
        acc_nxt        = '0;
        reg_nxt        = '0;
        digit_seen_nxt = 1'b0;
        bytes_nxt      = '0;
        err_nxt        = 1'b0;
      end else if (!err_r) begin
        case (step_r)
          STEP_START: begin
            if (in_byte_r == CH_M) begin
              step_nxt = STEP_MOV_O;
            end else if (in_byte_r == CH_S) begin
              step_nxt = STEP_SVC_V;
            end else if (in_byte_r == CH_R) begin
              step_nxt = STEP_RET_E;
            end else begin
              err_nxt = 1'b1;
            end
          end
          STEP_MOV_O, STEP_MOV_V, STEP_MOV_SP, STEP_MOV_X,
          STEP_SVC_V, STEP_SVC_C, STEP_SVC_SP, STEP_SVC_HASH, STEP_SVC_ZERO,
          STEP_RET_E, STEP_RET_T: begin
            if (in_byte_r == exp_char) begin
              step_nxt = step_succ;
              if (step_r == STEP_MOV_X) begin
                acc_nxt        = '0;
                digit_seen_nxt = 1'b0;
              end
            end else begin
              err_nxt = 1'b1;
            end
          end
          STEP_REG: begin
            if (is_digit) begin
              if (num_over) begin
                err_nxt = 1'b1;
              end else begin
                acc_nxt        = acc_x10[NUM_W-1:0];
                digit_seen_nxt = 1'b1;
              end
            end else if (in_byte_r == CH_COMMA && digit_seen_r &&
                         acc_r <= REG_LIMIT) begin
              reg_nxt        = acc_r[REG_W-1:0];
              acc_nxt        = '0;
              digit_seen_nxt = 1'b0;
              step_nxt       = STEP_COMMA;
            end else begin
              err_nxt = 1'b1;
            end
          end
          STEP_COMMA: begin
            if (in_byte_r == CH_SPACE) begin
              step_nxt = STEP_HASH;
            end else begin
              err_nxt = 1'b1;
            end
          end
          STEP_HASH: begin
            if (in_byte_r == CH_HASH) begin
              acc_nxt        = '0;
              digit_seen_nxt = 1'b0;
              step_nxt       = STEP_IMM;
            end else begin
              err_nxt = 1'b1;
            end
          end
          STEP_IMM: begin
            if (is_digit) begin
              if (num_over) begin
                err_nxt = 1'b1;
              end else begin
                acc_nxt        = acc_x10[NUM_W-1:0];
                digit_seen_nxt = 1'b1;
              end
            end else if (in_byte_r == CH_NL && digit_seen_r) begin
              line_done = 1'b1;
              line_word = WORD_MOVZ | {11'd0, acc_r, reg_r};
            end else begin
              err_nxt = 1'b1;
            end
          end
          STEP_SVC_NL, STEP_RET_NL: begin
            if (in_byte_r == CH_NL) begin
              line_done = 1'b1;
              line_word = (step_r == STEP_SVC_NL) ? WORD_SVC : WORD_RET;
            end else begin
              err_nxt = 1'b1;
            end
          end
          default: begin
            err_nxt = 1'b1;
          end
        endcase

        // A completed line either emits its word or fails on capacity, in
        // which case the parser state is left where it was.
        if (line_done) begin
          if (cap_over) begin
            err_nxt = 1'b1;
          end else begin
            res_valid      = 1'b1;
            kind_nxt       = KIND_WORD;
            word_nxt       = line_word;
            ofs_nxt        = bytes_r[OFS_W-1:0];
            bytes_nxt      = bytes_plus4[CNT_W-1:0];
            step_nxt       = STEP_START;
            acc_nxt        = '0;
            reg_nxt        = '0;
            digit_seen_nxt = 1'b0;
          end
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      step_r       <= STEP_START;
      acc_r        <= '0;
      reg_r        <= '0;
      digit_seen_r <= 1'b0;
      bytes_r      <= '0;
      err_r        <= 1'b0;
      cap_r        <= CAP_RESET;
    end else begin
      if (in_if.ready) begin
        in_valid_r <= in_if.valid;
      end
      if (out_free) begin
        out_valid_r <= res_valid;
      end
      step_r       <= step_nxt;
      acc_r        <= acc_nxt;
      reg_r        <= reg_nxt;
      digit_seen_r <= digit_seen_nxt;
      bytes_r      <= bytes_nxt;
      err_r        <= err_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r <= in_if.src_byte;
      in_end_r  <= in_if.end_mark;
    end
    if (process && res_valid) begin
      kind_r   <= kind_nxt;
      word_r   <= word_nxt;
      ofs_r    <= ofs_nxt;
      total_r  <= total_nxt;
      failed_r <= failed_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.out_kind    = kind_r;
  assign out_if.instr_word  = word_r;
  assign out_if.byte_offset = ofs_r;
  assign out_if.total_bytes = total_r;
  assign out_if.failed      = failed_r;

endmodule

@@ tb/a64_subset_line_assembler_unit_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// a64_subset_line_assembler_unit_tb: self-checking bench for the line assembler
// Feeds source text one byte per transaction and checks every emitted word and
// run report against a cycle-free predictor kept in a small scoreboard class.
// ============================================================================
module a64_subset_line_assembler_unit_tb
  import a64la_pkg::*;
();

  localparam int unsigned IMM_MAX        = 65535;
  // A run in which no transaction moves for this many cycles is considered hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Idle time after the last result that lets the pipeline run empty.
  localparam int unsigned SETTLE_CYCLES  = 6;
  // Every line produces four bytes of code, so 256 lines fill the 1024 bytes.
  localparam int unsigned FULL_LINES     = 256;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] word;
    logic [OFS_W-1:0]  offset;
    logic [CNT_W-1:0]  total;
    logic              failed;
  } asm_result_t;

  // The scoreboard carries its own copy of the parser state and the capacity
  // register. Each accepted input transaction advances that state and, where a
  // line or a run closes, queues the result the block has to produce.
  class line_asm_scoreboard;
    asm_result_t       pending_results[$];
    int unsigned       mismatches;
    int unsigned       live_items;
    logic [CNT_W-1:0]  capacity;
    logic [STEP_W-1:0] step;
    int unsigned       num_acc;
    logic [REG_W-1:0]  reg_sel;
    logic              have_digit;
    logic [CNT_W-1:0]  code_bytes;
    logic              latched_err;

    function new();
      capacity = CAP_RESET;
      clear_run();
    endfunction

    function void clear_run();
      step        = STEP_START;
      num_acc     = 0;
      reg_sel     = '0;
      have_digit  = 1'b0;
      code_bytes  = '0;
      latched_err = 1'b0;
    endfunction

    function void set_capacity(logic [CNT_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction

    function void take_digit(logic [SRC_W-1:0] c);
      int unsigned v;
      v = num_acc * 10 + int'(c - CH_ZERO);
      if (v > IMM_MAX) begin
        latched_err = 1'b1;
      end else begin
        num_acc    = v;
        have_digit = 1'b1;
      end
    endfunction

    // A line that does not fit under the capacity (clamped to 1024) latches
    // the error and produces nothing.
    function void close_line(logic [WORD_W-1:0] word);
      logic [CNT_W-1:0] cap;
      asm_result_t r;
      cap = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
      if ((CNT_W+1)'(code_bytes) + (CNT_W+1)'(4) > (CNT_W+1)'(cap)) begin
        latched_err = 1'b1;
        return;
      end
      r = '{KIND_WORD, word, code_bytes[OFS_W-1:0], '0, 1'b0};
      pending_results.push_back(r);
      code_bytes = code_bytes + CNT_W'(4);
      step       = STEP_START;
      num_acc    = 0;
      reg_sel    = '0;
      have_digit = 1'b0;
    endfunction

    function void note_input(logic [SRC_W-1:0] c, logic endm);
      logic is_digit;
      logic bad;
      asm_result_t r;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      live_items++;
      if (endm) begin
        bad = latched_err || (step != STEP_START);
        r = '{KIND_REPORT, '0, '0, bad ? '0 : code_bytes, bad};
        pending_results.push_back(r);
        clear_run();
        return;
      end
      // Bytes after an error are dropped until the end transaction.
      if (latched_err) return;
      case (step)
        STEP_START: begin
          if (c == CH_M) step = STEP_MOV_O;
          else if (c == CH_S) step = STEP_SVC_V;
          else if (c == CH_R) step = STEP_RET_E;
          else latched_err = 1'b1;
        end
        STEP_MOV_O: begin
          if (c == CH_O) step = STEP_MOV_V; else latched_err = 1'b1;
        end
        STEP_MOV_V: begin
          if (c == CH_V) step = STEP_MOV_SP; else latched_err = 1'b1;
        end
        STEP_MOV_SP: begin
          if (c == CH_SPACE) step = STEP_MOV_X; else latched_err = 1'b1;
        end
        STEP_MOV_X: begin
          if (c == CH_X) begin
            step       = STEP_REG;
            num_acc    = 0;
            have_digit = 1'b0;
          end else begin
            latched_err = 1'b1;
          end
        end
        STEP_REG: begin
          if (is_digit) begin
            take_digit(c);
          end else if (c == CH_COMMA && have_digit && num_acc <= REG_LIMIT) begin
            reg_sel    = num_acc[REG_W-1:0];
            num_acc    = 0;
            have_digit = 1'b0;
            step       = STEP_COMMA;
          end else begin
            latched_err = 1'b1;
          end
        end
        STEP_COMMA: begin
          if (c == CH_SPACE) step = STEP_HASH; else latched_err = 1'b1;
        end
        STEP_HASH: begin
          if (c == CH_HASH) begin
            num_acc    = 0;
            have_digit = 1'b0;
            step       = STEP_IMM;
          end else begin
            latched_err = 1'b1;
          end
        end
        STEP_IMM: begin
          if (is_digit) take_digit(c);
          else if (c == CH_NL && have_digit)
            close_line(WORD_MOVZ | (WORD_W'(num_acc[NUM_W-1:0]) << 5) | WORD_W'(reg_sel));
          else latched_err = 1'b1;
        end
        STEP_SVC_V: begin
          if (c == CH_V) step = STEP_SVC_C; else latched_err = 1'b1;
        end
        STEP_SVC_C: begin
          if (c == CH_C) step = STEP_SVC_SP; else latched_err = 1'b1;
        end
        STEP_SVC_SP: begin
          if (c == CH_SPACE) step = STEP_SVC_HASH; else latched_err = 1'b1;
        end
        STEP_SVC_HASH: begin
          if (c == CH_HASH) step = STEP_SVC_ZERO; else latched_err = 1'b1;
        end
        STEP_SVC_ZERO: begin
          if (c == CH_ZERO) step = STEP_SVC_NL; else latched_err = 1'b1;
        end
        STEP_RET_E: begin
          if (c == CH_E) step = STEP_RET_T; else latched_err = 1'b1;
        end
        STEP_RET_T: begin
          if (c == CH_T) step = STEP_RET_NL; else latched_err = 1'b1;
        end
        STEP_SVC_NL: begin
          if (c == CH_NL) close_line(WORD_SVC); else latched_err = 1'b1;
        end
        STEP_RET_NL: begin
          if (c == CH_NL) close_line(WORD_RET); else latched_err = 1'b1;
        end
        default: latched_err = 1'b1;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(asm_result_t got);
      asm_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, kind %0h word %0h total %0h failed %0h",
                 $time, got.kind, got.word, got.total, got.failed);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("out_kind", want.kind, got.kind);
      compare_field("instr_word", want.word, got.word);
      compare_field("byte_offset", want.offset, got.offset);
      compare_field("total_bytes", want.total, got.total);
      compare_field("failed", want.failed, got.failed);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  a64la_in_if  src_ch ();
  a64la_out_if res_ch ();

  line_asm_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles = 0;
  logic [SRC_W-1:0] line_text[$];

  a64_subset_line_assembler_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (src_ch),
    .out_if    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver drops ready at random, as the current phase asks.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result monitor and watchdog. Signals are read right after the edge, so
  // they hold the values the block saw at that edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        sb.check_result('{res_ch.out_kind, res_ch.instr_word, res_ch.byte_offset,
                          res_ch.total_bytes, res_ch.failed});
      end
      if ((src_ch.valid && src_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one input transaction, with a random idle gap in front of it,
  // and hands it to the scoreboard at the edge where it is accepted. Valid is
  // left high afterwards so that back-to-back transactions need no extra edge.
  task automatic send_item(input logic [SRC_W-1:0] ch, input logic endm);
    if ($urandom_range(99) < send_idle_pct) begin
      src_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    src_ch.valid    <= 1'b1;
    src_ch.src_byte <= ch;
    src_ch.end_mark <= endm;
    do @(posedge clk); while (!src_ch.ready);
    sb.note_input(ch, endm);
  endtask

  // Stops the sender and waits until every queued result has come out, then
  // lets the pipeline run empty. Polling on the falling edge keeps the check
  // clear of the monitor's updates at the rising edge.
  task automatic settle_block();
    src_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending_count() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_capacity(value);
    cfg_we    <= 1'b0;
  endtask

  // Mostly small capacities so that the overflow check is hit often, plus
  // both ends of the register and a value past the 1024-byte clamp.
  function automatic logic [CNT_W-1:0] pick_capacity();
    case ($urandom_range(9))
      0:       return 11'd0;
      1:       return 11'd4;
      2:       return 11'd8;
      3:       return 11'd12;
      4:       return 11'd20;
      5:       return CAP_RESET;
      6:       return CAP_LIMIT;
      7:       return 11'h7ff;
      default: return CNT_W'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic string decimal_text(input int unsigned v, input bit missing);
    string txt;
    txt = "";
    if (missing) return txt;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) txt = {txt, "0"};
    end
    return {txt, $sformatf("%0d", v)};
  endfunction

  function automatic string reg_text();
    case ($urandom_range(19))
      0:       return decimal_text(30, 1'b0);
      1:       return decimal_text(0, 1'b0);
      2, 3:    return decimal_text($urandom_range(31, 99), 1'b0);
      4:       return decimal_text($urandom_range(65536, 99999), 1'b0);
      5:       return decimal_text(0, 1'b1);
      default: return decimal_text($urandom_range(0, 30), 1'b0);
    endcase
  endfunction

  function automatic string imm_text();
    case ($urandom_range(19))
      0:       return decimal_text(IMM_MAX, 1'b0);
      1:       return decimal_text(0, 1'b0);
      2:       return decimal_text(IMM_MAX + 1, 1'b0);
      3:       return decimal_text($urandom_range(65536, 999999), 1'b0);
      4:       return decimal_text(0, 1'b1);
      default: return decimal_text($urandom_range(0, IMM_MAX), 1'b0);
    endcase
  endfunction

  task automatic queue_text(input string txt);
    for (int i = 0; i < txt.len(); i++) line_text.push_back(txt[i]);
  endtask

  // Builds one source line into line_text. Most lines are well formed with
  // random operands; the rest are empty lines, pure noise, or a good line
  // with one byte replaced, inserted or dropped.
  task automatic compose_line();
    int unsigned choice;
    int unsigned pos;
    line_text.delete();
    choice = $urandom_range(99);
    if (choice < 55) begin
      queue_text({"mov x", reg_text(), ", #", imm_text(), "\n"});
    end else if (choice < 70) begin
      queue_text("svc #0\n");
    end else if (choice < 85) begin
      queue_text("ret\n");
    end else if (choice < 88) begin
      queue_text("\n");
    end else begin
      repeat ($urandom_range(1, 6)) line_text.push_back(SRC_W'($urandom_range(255)));
      line_text.push_back(CH_NL);
    end
    if (choice < 85 && $urandom_range(99) < 12) begin
      pos = $urandom_range(0, line_text.size() - 1);
      case ($urandom_range(2))
        0:       line_text[pos] = SRC_W'($urandom_range(255));
        1:       line_text.insert(pos, SRC_W'($urandom_range(255)));
        default: line_text.delete(pos);
      endcase
    end
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_item(txt[i], 1'b0);
  endtask

  task automatic end_run();
    send_item(SRC_W'($urandom_range(255)), 1'b1);
  endtask

  // One run: a handful of lines and the end transaction. Now and then the
  // last line is cut short so that the run ends in mid-line.
  task automatic random_run();
    int unsigned lines;
    lines = $urandom_range(0, 7);
    for (int n = 0; n < lines; n++) begin
      compose_line();
      if (n == lines - 1 && $urandom_range(9) == 0 && line_text.size() > 1)
        line_text = line_text[0:$urandom_range(0, line_text.size() - 2)];
      foreach (line_text[i]) send_item(line_text[i], 1'b0);
    end
    end_run();
  endtask

  initial begin
    int unsigned target;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    src_ch.valid    = 1'b0;
    src_ch.src_byte = '0;
    src_ch.end_mark = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at the reset capacity: an empty run, the largest
    // register and immediate, a ret line, and a run that ends in mid-line.
    end_run();
    send_text("mov x30, #65535\n");
    send_text("ret\n");
    end_run();
    send_text("s");
    end_run();

    // Fill the whole 1024 bytes under a capacity above the clamp, which
    // walks the offset through every multiple of four up to 1020.
    settle_block();
    write_capacity(11'h7ff);
    for (int n = 0; n < FULL_LINES; n++) begin
      if ($urandom_range(7) == 0) send_text("svc #0\n");
      else send_text("ret\n");
    end
    end_run();

    // Random runs in four flow-control phases: free flowing, a sparse
    // sender, a stalling receiver, and light pressure on both sides.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 78; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      settle_block();
      write_capacity(pick_capacity());
      target = sb.live_items + ((ph == 0) ? 100 : 200);
      while (sb.live_items < target) begin
        if ($urandom_range(3) == 0) begin
          settle_block();
          write_capacity(pick_capacity());
        end
        random_run();
      end
    end

    settle_block();
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
